@@ hw/rtl/smte_pkg.sv @@
// ----------------------------------------------------------------------------
// smte_pkg: shared types and constants of the static MAC table engine
// Field widths, request opcodes, status codes, controller states and the
// per-cell control group.
// ----------------------------------------------------------------------------
package smte_pkg;

    // Default sizing
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_PORT_BITS   = 16;

    // Fixed field widths of the request and result channels
    localparam int OPCODE_W    = 2;
    localparam int ADDR_W      = 48;
    localparam int VLAN_W      = 8;
    localparam int MASK_IN_W   = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOMATCH = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    // Per-cell update controls, mutually exclusive by opcode
    typedef struct packed {
        logic write_new;    // load the request key and port vector
        logic update_mask;  // replace the port vector only
        logic shift;        // take the upper neighbor's entry
    } t_cell_ctl;

endpackage

@@ hw/rtl/smte_cell.sv @@
// ----------------------------------------------------------------------------
// smte_cell: one table slot
// Holds one entry, registers its match against the request key every cycle
// and presents its entry to the lower neighbor for delete shifts.
// ----------------------------------------------------------------------------
module smte_cell #(
    parameter int PORT_BITS = smte_pkg::DEF_PORT_BITS
) (
    input  logic                         i_clk,
    input  smte_pkg::t_cell_ctl          i_ctl,
    input  logic                         i_live,
    input  logic [smte_pkg::ADDR_W-1:0]  i_key_addr,
    input  logic [smte_pkg::VLAN_W-1:0]  i_key_vlan,
    input  logic [PORT_BITS-1:0]         i_key_mask,
    input  logic [smte_pkg::ADDR_W-1:0]  i_nbr_addr,
    input  logic [smte_pkg::VLAN_W-1:0]  i_nbr_vlan,
    input  logic [PORT_BITS-1:0]         i_nbr_mask,
    output logic [smte_pkg::ADDR_W-1:0]  o_addr,
    output logic [smte_pkg::VLAN_W-1:0]  o_vlan,
    output logic [PORT_BITS-1:0]         o_mask,
    output logic                         o_hit
);

    logic [smte_pkg::ADDR_W-1:0] r_addr;
    logic [smte_pkg::VLAN_W-1:0] r_vlan;
    logic [PORT_BITS-1:0]        r_mask;
    logic                        r_hit;

    // Load, shift or patch the stored entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_new) begin
            r_addr <= i_key_addr;
            r_vlan <= i_key_vlan;
            r_mask <= i_key_mask;
        end else if (i_ctl.shift) begin
            r_addr <= i_nbr_addr;
            r_vlan <= i_nbr_vlan;
            r_mask <= i_nbr_mask;
        end else if (i_ctl.update_mask) begin
            r_mask <= i_key_mask;
        end
    end

    // Register the live-entry match
    always_ff @(posedge i_clk) begin
        r_hit <= i_live && (r_addr == i_key_addr) && (r_vlan == i_key_vlan);
    end

    assign o_addr = r_addr;
    assign o_vlan = r_vlan;
    assign o_mask = r_mask;
    assign o_hit  = r_hit;

endmodule

@@ hw/rtl/static_mac_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// static_mac_table_engine_core: static MAC address table
// Ordered table of address/VLAN/port-vector entries with add, modify and
// delete requests, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request goes from acceptance to a loaded result as follows: the key
// is captured at acceptance, then a compare state in which every cell
// registers its own match, then an apply state that updates every matching
// cell, appends at the fill count, or shifts all cells from the first match
// up, found with a prefix OR over the match row. The next request is
// accepted in the cycle after the result is loaded; none is taken while one
// is in flight, and a result left waiting holds the apply cycle. Table
// contents need no clearing; reset clears the state, fill count and result
// valid, so the block accepts a request as soon as reset is released.
module static_mac_table_engine_core #(
    parameter int TABLE_DEPTH = smte_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_BITS   = smte_pkg::DEF_PORT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [smte_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [smte_pkg::ADDR_W-1:0]       i_mac_addr,
    input  logic [smte_pkg::VLAN_W-1:0]       i_vlan_id,
    input  logic [smte_pkg::MASK_IN_W-1:0]    i_port_mask,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [smte_pkg::STATUS_W-1:0]     o_status,
    output logic [smte_pkg::COUNT_OUT_W-1:0]  o_entry_count
);

    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DEPTH_LOG = $clog2(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

    smte_pkg::t_state r_state;
    smte_pkg::t_state n_state;

    logic [smte_pkg::OPCODE_W-1:0]    r_op;
    logic [smte_pkg::ADDR_W-1:0]      r_addr;
    logic [smte_pkg::VLAN_W-1:0]      r_vlan;
    logic [PORT_BITS-1:0]             r_mask;
    logic [COUNT_W-1:0]               r_count;
    logic [COUNT_W-1:0]               n_count;
    logic                             r_out_valid;
    logic [smte_pkg::STATUS_W-1:0]    r_out_status;
    logic [smte_pkg::STATUS_W-1:0]    n_status;
    logic [smte_pkg::COUNT_OUT_W-1:0] r_out_count;

    logic                                     w_accept;
    logic                                     w_fire;
    logic                                     w_full;
    logic                                     w_any_hit;
    logic [PORT_BITS+smte_pkg::MASK_IN_W-1:0] w_pm_ext;
    logic [COUNT_W+smte_pkg::COUNT_OUT_W-1:0] w_count_ext;
    logic [TABLE_DEPTH-1:0]                   w_live;
    logic [TABLE_DEPTH-1:0]                   w_hit;
    logic [TABLE_DEPTH-1:0]                   w_seen;
    logic [TABLE_DEPTH-1:0]                   w_add_sel;
    logic [TABLE_DEPTH-1:0]                   w_shift_vec;
    smte_pkg::t_cell_ctl                      w_ctl [TABLE_DEPTH];

    logic [smte_pkg::ADDR_W-1:0] w_cell_addr [TABLE_DEPTH+1];
    logic [smte_pkg::VLAN_W-1:0] w_cell_vlan [TABLE_DEPTH+1];
    logic [PORT_BITS-1:0]        w_cell_mask [TABLE_DEPTH+1];

    assign w_accept = i_valid && !o_stall;
    assign w_fire   = (r_state == smte_pkg::S_APPLY) && (!r_out_valid || !i_stall);
    assign w_full   = (r_count >= FULL_COUNT);
    assign w_pm_ext = {{PORT_BITS{1'b0}}, i_port_mask};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smte_pkg::S_IDLE:  if (w_accept) n_state = smte_pkg::S_CMP;
            smte_pkg::S_CMP:   n_state = smte_pkg::S_APPLY;
            smte_pkg::S_APPLY: if (w_fire) n_state = smte_pkg::S_IDLE;
            default:           n_state = smte_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        unique case (r_state)
            smte_pkg::S_IDLE: o_stall = 1'b0;
            default:          o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request key
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_addr <= i_mac_addr;
            r_vlan <= i_vlan_id;
            r_mask <= w_pm_ext[PORT_BITS-1:0];
        end
    end

    // First-match search: prefix OR of the registered match row
    always_comb begin
        w_seen = w_hit;
        for (int k = 0; k < DEPTH_LOG; k++) begin
            w_seen = w_seen | (w_seen << (1 << k));
        end
    end
    assign w_any_hit = |w_hit;

    // Row of slot cells; each passes its entry down to the lower neighbor
    assign w_cell_addr[TABLE_DEPTH] = '0;
    assign w_cell_vlan[TABLE_DEPTH] = '0;
    assign w_cell_mask[TABLE_DEPTH] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_live[g]      = (COUNT_W'(g) < r_count);
        assign w_add_sel[g]   = w_fire && (r_op == smte_pkg::OP_ADD) && !w_full
                                && (r_count == COUNT_W'(g));
        assign w_shift_vec[g] = w_fire && (r_op == smte_pkg::OP_DELETE) && w_seen[g];
        assign w_ctl[g].write_new   = w_add_sel[g];
        assign w_ctl[g].shift       = w_shift_vec[g];
        assign w_ctl[g].update_mask = w_fire && (r_op == smte_pkg::OP_MODIFY) && w_hit[g];

        smte_cell #(
            .PORT_BITS (PORT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_live     (w_live[g]),
            .i_key_addr (r_addr),
            .i_key_vlan (r_vlan),
            .i_key_mask (r_mask),
            .i_nbr_addr (w_cell_addr[g+1]),
            .i_nbr_vlan (w_cell_vlan[g+1]),
            .i_nbr_mask (w_cell_mask[g+1]),
            .o_addr     (w_cell_addr[g]),
            .o_vlan     (w_cell_vlan[g]),
            .o_mask     (w_cell_mask[g]),
            .o_hit      (w_hit[g])
        );
    end

    // Status and new fill count
    always_comb begin
        n_status = smte_pkg::STS_DONE;
        n_count  = r_count;
        unique case (r_op)
            smte_pkg::OP_ADD: begin
                if (w_full) begin
                    n_status = smte_pkg::STS_FULL;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            smte_pkg::OP_MODIFY: begin
                if (!w_any_hit) n_status = smte_pkg::STS_NOMATCH;
            end
            smte_pkg::OP_DELETE: begin
                if (!w_any_hit) begin
                    n_status = smte_pkg::STS_NOMATCH;
                end else begin
                    n_count = r_count - COUNT_W'(1);
                end
            end
            default: begin
                n_status = smte_pkg::STS_DONE;
            end
        endcase
    end
    assign w_count_ext = {{smte_pkg::COUNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    // Output register: load on apply, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= n_status;
            r_out_count  <= w_count_ext[smte_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count beyond table depth");

    // An add writes at most one slot
    a_add_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_add_sel))
        else $error("add wrote more than one slot");

    // Cells shift only in the apply cycle
    a_shift_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != smte_pkg::S_APPLY) |-> (w_shift_vec == '0))
        else $error("shift outside apply cycle");

    // Fill count moves only on an applied request
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("fill count changed without a request");

    // A result appears only out of the apply cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == smte_pkg::S_APPLY))
        else $error("result without apply");

endmodule
